>>> hw/rtl/mi4_pkg.sv
package mi4_pkg;

  // Default number of fraction bits of the fixed-point elements.
  localparam int FRAC_BITS_DEF = 16;

  localparam int ELEM_W  = 32;
  localparam int ADDR_W  = 4;
  // A product of an element and one 33-bit limb.
  localparam int LIMB_W  = 33;
  localparam int PROD_W  = ELEM_W + LIMB_W;
  // A 2x2 minor, a 3x3 cofactor and the determinant, all held exactly.
  localparam int MINOR_W = 65;
  localparam int COF_W   = 97;
  localparam int ACC_W   = 131;
  // Quotient bits produced by the restoring divider.
  localparam int QBITS   = 33;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;

  localparam logic [ADDR_W-1:0] LAST_ADDR = 4'd15;

  typedef struct packed {
    logic signed [ELEM_W-1:0] element;
    logic [ADDR_W-1:0]        addr;
  } q_entry_t;

  typedef struct packed {
    logic     valid;
    q_entry_t entry;
  } q_head_t;

  typedef enum logic [3:0] {
    B_LOAD,
    B_RD_E,
    B_RD_W,
    B_MUL,
    B_ACC,
    B_STORE,
    B_DET,
    B_DIV_INIT,
    B_DIV_BIG,
    B_DIV_STEP,
    B_FIN,
    B_OUT
  } back_state_t;

  // The n-th index of 0..3 once the index skip is struck out.
  function automatic logic [1:0] other_idx(input logic [1:0] skip, input logic [1:0] n);
    return (n < skip) ? n : n + 2'd1;
  endfunction

endpackage

>>> hw/rtl/matrix_inverse_4x4.sv
// After the sixteenth element the back builds the cofactors, then the determinant,
// then divides out each result in turn.
// The next matrix is taken from the queue only after its last result; a singular
// matrix skips the division. The shared multiplier and the
// one-bit-per-cycle divider set the pace. Reset clears the load counter, the
// element queue and the sequencer; the element store needs no clearing.
module matrix_inverse_4x4 #(
  parameter int FRAC_BITS = mi4_pkg::FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic signed [31:0] element,
  input  logic               element_valid,
  output logic               element_ready,
  output logic signed [31:0] inverse_value,
  output logic               singular,
  output logic               saturated,
  output logic               last,
  output logic               result_valid,
  input  logic               result_ready
);
  import mi4_pkg::*;

  // The front tags each item with its place in the matrix and queues it, so
  // that loading of the next matrix can begin while results are delivered.
  q_head_t head;
  logic    pop;

  mi4_front u_front (
    .clk           (clk),
    .rst           (rst),
    .element       (element),
    .element_valid (element_valid),
    .element_ready (element_ready),
    .pop           (pop),
    .head          (head)
  );

  // The back stores the elements, builds all sixteen cofactors exactly with a
  // single 32x33 multiplier, expands the determinant along the first row, and
  // divides each adjugate entry by it, unless it is zero, with round-to-nearest and saturation.
  mi4_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk           (clk),
    .rst           (rst),
    .head          (head),
    .pop           (pop),
    .result_valid  (result_valid),
    .result_ready  (result_ready),
    .inverse_value (inverse_value),
    .singular      (singular),
    .saturated     (saturated),
    .last          (last)
  );

endmodule

>>> hw/rtl/mi4_ram.sv
module mi4_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> hw/rtl/mi4_front.sv
module mi4_front (
  input  logic                clk,
  input  logic                rst,
  input  logic signed [31:0]  element,
  input  logic                element_valid,
  output logic                element_ready,
  input  logic                pop,
  output mi4_pkg::q_head_t    head
);
  import mi4_pkg::*;

  logic [ADDR_W-1:0] load_count;
  q_entry_t          queue [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   fill;
  logic              push;

  assign element_ready = (fill != (QPTR_W+1)'(QUEUE_DEPTH));
  assign push          = element_valid && element_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      load_count <= '0;
      wr_ptr     <= '0;
      rd_ptr     <= '0;
      fill       <= '0;
    end else begin
      if (push) begin
        load_count <= load_count + 1'b1;
        wr_ptr     <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      fill <= fill + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
    end
  end

  // Each element is tagged with its place in the matrix.
  always_ff @(posedge clk) begin
    if (push) begin
      queue[wr_ptr] <= '{element: element, addr: load_count};
    end
  end

  assign head.valid = (fill != '0);
  assign head.entry = queue[rd_ptr];

endmodule

>>> hw/rtl/mi4_back.sv
module mi4_back #(
  parameter int FRAC_BITS = mi4_pkg::FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  mi4_pkg::q_head_t   head,
  output logic               pop,
  output logic               result_valid,
  input  logic               result_ready,
  output logic signed [31:0] inverse_value,
  output logic               singular,
  output logic               saturated,
  output logic               last
);
  import mi4_pkg::*;

  localparam int NUM_W = 2 * FRAC_BITS + COF_W + 2;
  localparam int DIV_W = (NUM_W > ACC_W + QBITS) ? NUM_W : ACC_W + QBITS;

  back_state_t state, state_next;

  logic [3:0] k;
  logic [1:0] t, o, l, j;
  logic       det_phase;
  logic [5:0] cnt;

  logic signed [ELEM_W-1:0]  e_reg;
  logic signed [PROD_W-1:0]  prod;
  logic signed [MINOR_W-1:0] minor;
  logic signed [ACC_W-1:0]   acc;
  logic signed [COF_W-1:0]   cof [16];
  logic [ACC_W-1:0]          det_mag;
  logic                      det_neg;
  logic                      sing;
  logic                      adj_neg;
  logic [DIV_W-1:0]          rem, dsh;
  logic [QBITS-1:0]          q;

  logic                      ram_re;
  logic [ADDR_W-1:0]         ram_raddr;
  logic [ELEM_W-1:0]         ram_rdata;

  logic [1:0] r, c, r0, r1, r2, ct, u, v;
  logic [ADDR_W-1:0]         e_addr, w_addr, cof_idx;
  logic                      w_is_elem;
  logic [1:0]                lmax;
  logic signed [COF_W-1:0]   cof_sel;
  logic signed [LIMB_W-1:0]  limb;
  logic signed [ACC_W-1:0]   prod_sh;
  logic                      acc_sub;
  logic [COF_W-1:0]          adj_mag;
  logic [DIV_W-1:0]          num;
  logic [DIV_W-1:0]          dsh_init;
  logic                      big;
  logic                      ge;
  logic                      res_neg;
  logic [31:0]               ident;

  mi4_ram #(.WIDTH(ELEM_W), .DEPTH(16)) u_store (
    .clk   (clk),
    .we    (pop),
    .waddr (head.entry.addr),
    .wdata (head.entry.element),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Operand addressing for cofactor k, term t, operation o.
  assign r  = k[3:2];
  assign c  = k[1:0];
  assign r0 = other_idx(r, 2'd0);
  assign r1 = other_idx(r, 2'd1);
  assign r2 = other_idx(r, 2'd2);
  assign ct = other_idx(c, t);
  assign u  = other_idx(c, (t == 2'd0) ? 2'd1 : 2'd0);
  assign v  = other_idx(c, (t == 2'd2) ? 2'd1 : 2'd2);

  always_comb begin
    if (det_phase) begin
      e_addr = {2'd0, j};
    end else begin
      unique case (o)
        2'd0:    e_addr = {r1, u};
        2'd1:    e_addr = {r1, v};
        default: e_addr = {r0, ct};
      endcase
    end
  end

  assign w_addr    = (o == 2'd0) ? {r2, v} : {r2, u};
  assign w_is_elem = !det_phase && (o != 2'd2);
  assign lmax      = det_phase ? 2'd2 : ((o == 2'd2) ? 2'd1 : 2'd0);
  assign cof_idx   = (state == B_DIV_INIT) ? {k[1:0], k[3:2]} : {2'd0, j};
  assign cof_sel   = cof[cof_idx];

  always_comb begin
    if (w_is_elem) begin
      limb = {ram_rdata[ELEM_W-1], ram_rdata};
    end else if (!det_phase) begin
      limb = (l == 2'd0) ? {1'b0, minor[31:0]} : minor[64:32];
    end else begin
      unique case (l)
        2'd0:    limb = {1'b0, cof_sel[31:0]};
        2'd1:    limb = {1'b0, cof_sel[63:32]};
        default: limb = cof_sel[96:64];
      endcase
    end
  end

  assign prod_sh = ACC_W'(prod) <<< {l, 5'd0};
  assign acc_sub = !det_phase && (t == 2'd1);

  // Division setup: q = (2*|adj|*2^(2F) + |det|) / (2*|det|).
  assign adj_mag  = cof_sel[COF_W-1] ? COF_W'(-cof_sel) : COF_W'(cof_sel);
  assign num      = (DIV_W'(adj_mag) << (2 * FRAC_BITS + 1)) + DIV_W'(det_mag);
  assign dsh_init = DIV_W'(det_mag) << QBITS;
  assign big      = {1'b0, rem} >= {dsh, 1'b0};
  assign ge       = rem >= dsh;
  assign res_neg  = adj_neg ^ det_neg;
  assign ident    = (k[3:2] == k[1:0]) ? (32'd1 << FRAC_BITS) : 32'd0;

  assign result_valid = (state == B_OUT);
  assign singular     = sing;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_LOAD;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    pop        = 1'b0;
    ram_re     = 1'b0;
    ram_raddr  = e_addr;
    unique case (state)
      B_LOAD: begin
        if (head.valid) begin
          pop = 1'b1;
          if (head.entry.addr == LAST_ADDR) begin
            state_next = B_RD_E;
          end
        end
      end
      B_RD_E: begin
        ram_re     = 1'b1;
        state_next = B_RD_W;
      end
      B_RD_W: begin
        if (w_is_elem) begin
          ram_re    = 1'b1;
          ram_raddr = w_addr;
        end
        state_next = B_MUL;
      end
      B_MUL: state_next = B_ACC;
      B_ACC: begin
        if (l != lmax) begin
          state_next = B_MUL;
        end else if (det_phase) begin
          state_next = (j == 2'd3) ? B_DET : B_RD_E;
        end else if (o != 2'd2 || t != 2'd2) begin
          state_next = B_RD_E;
        end else begin
          state_next = B_STORE;
        end
      end
      B_STORE:    state_next = B_RD_E;
      B_DET:      state_next = B_DIV_INIT;
      B_DIV_INIT: state_next = sing ? B_OUT : B_DIV_BIG;
      B_DIV_BIG:  state_next = big ? B_OUT : B_DIV_STEP;
      B_DIV_STEP: state_next = (cnt == 6'd0) ? B_FIN : B_DIV_STEP;
      B_FIN:      state_next = B_OUT;
      B_OUT: begin
        if (result_ready) begin
          state_next = (k == 4'd15) ? B_LOAD : B_DIV_INIT;
        end
      end
    endcase
  end

  // Sequencing counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      k         <= '0;
      t         <= '0;
      o         <= '0;
      l         <= '0;
      j         <= '0;
      det_phase <= 1'b0;
      cnt       <= '0;
    end else begin
      unique case (state)
        B_LOAD: begin
          if (head.valid && head.entry.addr == LAST_ADDR) begin
            k         <= '0;
            t         <= '0;
            o         <= '0;
            l         <= '0;
            j         <= '0;
            det_phase <= 1'b0;
          end
        end
        B_ACC: begin
          if (l != lmax) begin
            l <= l + 2'd1;
          end else begin
            l <= '0;
            if (det_phase) begin
              j <= j + 2'd1;
            end else if (o != 2'd2) begin
              o <= o + 2'd1;
            end else begin
              o <= '0;
              t <= (t != 2'd2) ? t + 2'd1 : 2'd0;
            end
          end
        end
        B_STORE: begin
          if (k == 4'd15) begin
            det_phase <= 1'b1;
            k         <= '0;
            j         <= '0;
          end else begin
            k <= k + 4'd1;
          end
        end
        B_DET:      k <= '0;
        B_DIV_BIG:  cnt <= 6'(QBITS - 1);
        B_DIV_STEP: cnt <= cnt - 6'd1;
        B_OUT: begin
          if (result_ready && k != 4'd15) begin
            k <= k + 4'd1;
          end
        end
        default: ;
      endcase
    end
  end

  // Datapath.
  always_ff @(posedge clk) begin
    unique case (state)
      B_LOAD: acc <= '0;
      B_RD_W: e_reg <= ram_rdata;
      B_MUL:  prod <= e_reg * limb;
      B_ACC: begin
        if (w_is_elem) begin
          minor <= (o == 2'd0) ? prod : minor - prod;
        end else if (acc_sub) begin
          acc <= acc - prod_sh;
        end else begin
          acc <= acc + prod_sh;
        end
      end
      B_STORE: begin
        cof[k] <= (k[2] ^ k[0]) ? -acc[COF_W-1:0] : acc[COF_W-1:0];
        acc    <= '0;
      end
      B_DET: begin
        det_mag <= acc[ACC_W-1] ? ACC_W'(-acc) : ACC_W'(acc);
        det_neg <= acc[ACC_W-1];
        sing    <= (acc == '0);
      end
      B_DIV_INIT: begin
        rem     <= num;
        dsh     <= dsh_init;
        adj_neg <= cof_sel[COF_W-1];
        q       <= '0;
        if (sing) begin
          inverse_value <= ident;
          saturated     <= 1'b0;
          last          <= (k == 4'd15);
        end
      end
      B_DIV_BIG: begin
        if (big) begin
          inverse_value <= res_neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
          saturated     <= 1'b1;
          last          <= (k == 4'd15);
        end
      end
      B_DIV_STEP: begin
        if (ge) begin
          rem <= rem - dsh;
        end
        q   <= {q[QBITS-2:0], ge};
        dsh <= dsh >> 1;
      end
      B_FIN: begin
        last <= (k == 4'd15);
        if (res_neg) begin
          if (q > 33'h0_8000_0000) begin
            inverse_value <= 32'h8000_0000;
            saturated     <= 1'b1;
          end else begin
            inverse_value <= 32'd0 - q[31:0];
            saturated     <= 1'b0;
          end
        end else begin
          if (q > 33'h0_7FFF_FFFF) begin
            inverse_value <= 32'h7FFF_FFFF;
            saturated     <= 1'b1;
          end else begin
            inverse_value <= q[31:0];
            saturated     <= 1'b0;
          end
        end
      end
      default: ;
    endcase
  end

endmodule

>>> hw/rtl/mi4_checker.sv
module mi4_checker (
  input logic               clk,
  input logic               rst,
  input logic signed [31:0] element,
  input logic               element_valid,
  input logic               element_ready,
  input logic signed [31:0] inverse_value,
  input logic               singular,
  input logic               saturated,
  input logic               last,
  input logic               result_valid,
  input logic               result_ready
);

  // A stalled result keeps its value and its end mark.
  assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(inverse_value) && $stable(last))
    else $error("result changed while stalled");

  // An offered element waits unchanged until it is taken.
  assert property (@(posedge clk) disable iff (rst)
    element_valid && !element_ready |=> element_valid && $stable(element))
    else $error("element changed while stalled");

  // The identity given for a singular matrix is never clipped.
  assert property (@(posedge clk) disable iff (rst)
    result_valid && singular |-> !saturated)
    else $error("singular result marked saturated");

  // A clipped result sits at one end of the range.
  assert property (@(posedge clk) disable iff (rst)
    result_valid && saturated |->
      inverse_value == 32'h7FFF_FFFF || inverse_value == 32'h8000_0000)
    else $error("saturated result not at a range limit");

  // No result comes out right after reset.
  assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result valid after reset");

endmodule

bind matrix_inverse_4x4 mi4_checker u_mi4_checker (.*);
